@@ hdl/stu_pkg.sv @@
`default_nettype none

package stu_pkg;

  // Table geometry.
  localparam int NUM_SLOTS  = 128;
  localparam int NUM_PROCS  = 64;
  localparam int COUNT_BITS = 16;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int PID_W  = $clog2(NUM_PROCS);
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int INIT_W = 16;

  // The free-slot search works on groups of eight slots.
  localparam int GRP       = 8;
  localparam int GRP_W     = $clog2(GRP);
  localparam int NUM_GRP   = NUM_SLOTS / GRP;
  localparam int GRP_IDX_W = SLOT_W - GRP_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POST   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // One word of the slot memory.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [PID_W-1:0]      head;
    logic [PID_W-1:0]      tail;
  } slot_word_t;

  // Result of the free-slot search.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_slot_t;

endpackage

`default_nettype wire

@@ hdl/stu_free_search.sv @@
`default_nettype none

module stu_free_search
  import stu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [NUM_SLOTS-1:0] slot_busy,
  output free_slot_t                free_o
);

  logic [NUM_GRP-1:0]  grp_free;
  logic [GRP_W-1:0]    grp_pos [NUM_GRP];
  logic [NUM_GRP-1:0]  grp_free_r;
  logic [GRP_W-1:0]    grp_pos_r [NUM_GRP];

  // First level: lowest free slot within each group of eight.
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_free[g] = 1'b0;
      grp_pos[g]  = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (!slot_busy[g*GRP + b]) begin
          grp_free[g] = 1'b1;
          grp_pos[g]  = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free_r <= grp_free;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_pos_r[g] <= grp_pos[g];
    end
  end

  // Second level: lowest group that has a free slot.
  always_comb begin
    free_o.found = 1'b0;
    free_o.slot  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        free_o.found = 1'b1;
        free_o.slot  = {GRP_IDX_W'(g), grp_pos_r[g]};
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/semaphore_table_unit_core.sv @@
// Semaphore table: 128 counting semaphores, each with a FIFO queue of
// waiting process ids kept as a linked list in a link memory.
// Input channel (in_valid/in_ready) carries one command per transaction:
// create, wait, post or close. The result channel (out_valid/out_ready)
// returns exactly one result transaction per command.
// The command and its slot word are registered when taken; the execute step
// then registers the result. A post that wakes a waiter with more waiters
// behind it passes through a link step as well, since the next waiter is read
// from the link memory after the queue head comes out of the slot memory.
// A new command is taken only in the idle state, after the previous command
// has registered its result.
// Create finds the lowest free slot through a two-level registered search
// over the in-use flags.
// Reset clears the in-use and queue flags directly; no clearing pass.
// Counts, queue pointers and links are undefined until written.
// When the receiver stalls, a new command is still taken, but it waits in the
// execute step (or the link step) until the output register is free.
`default_nettype none

module semaphore_table_unit_core
  import stu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [SLOT_W-1:0]     in_sem_index,
  input  wire logic [INIT_W-1:0]     in_initial_value,
  input  wire logic [PID_W-1:0]      in_caller_pid,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STAT_W-1:0]          out_status,
  output logic [SLOT_W-1:0]          out_slot_out,
  output logic                       out_wake_valid,
  output logic [PID_W-1:0]           out_wake_pid,
  output logic                       out_would_block
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [INIT_W-1:0]    init_r;
  logic [PID_W-1:0]     pid_r;
  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [NUM_SLOTS-1:0] qne_r, qne_nxt;

  // Slot memory (count, head, tail) and link memory (next waiter).
  slot_word_t           slot_mem [NUM_SLOTS];
  logic [PID_W-1:0]     link_mem [NUM_PROCS];
  slot_word_t           slot_rd_r;
  logic [PID_W-1:0]     link_rd_r;

  logic                 slot_we;
  logic [SLOT_W-1:0]    slot_wa;
  slot_word_t           slot_wd;
  logic                 link_we;
  logic [PID_W-1:0]     link_wa;
  logic [PID_W-1:0]     link_wd;
  logic                 link_re;

  logic                 out_valid_r;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [SLOT_W-1:0]    slot_out_r, slot_out_nxt;
  logic                 wake_valid_r, wake_valid_nxt;
  logic [PID_W-1:0]     wake_pid_r, wake_pid_nxt;
  logic                 would_block_r, would_block_nxt;
  logic                 res_fire;

  logic                 in_acc;
  logic                 out_free;
  logic                 slot_ok;
  free_slot_t           free_slot;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign slot_ok  = in_use_r[idx_r];

  stu_free_search u_free_search (
    .clk       (clk),
    .slot_busy (in_use_r),
    .free_o    (free_slot)
  );

  // Command capture and slot memory read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_command;
      idx_r     <= in_sem_index;
      init_r    <= in_initial_value;
      pid_r     <= in_caller_pid;
      slot_rd_r <= slot_mem[in_sem_index];
    end
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  // Link memory read and write.
  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rd_r <= link_mem[slot_rd_r.head];
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  // Execute: modify the slot word read when the command was taken and form the result.
  always_comb begin
    state_nxt       = state_r;
    in_use_nxt      = in_use_r;
    qne_nxt         = qne_r;
    slot_we         = 1'b0;
    slot_wa         = idx_r;
    slot_wd         = slot_rd_r;
    link_we         = 1'b0;
    link_wa         = slot_rd_r.tail;
    link_wd         = pid_r;
    link_re         = 1'b0;
    res_fire        = 1'b0;
    status_nxt      = ST_OK;
    slot_out_nxt    = idx_r;
    wake_valid_nxt  = 1'b0;
    wake_pid_nxt    = '0;
    would_block_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == CMD_POST && slot_ok && qne_r[idx_r] &&
            slot_rd_r.head != slot_rd_r.tail) begin
          // Waiter behind the head: fetch its link first.
          link_re   = 1'b1;
          state_nxt = S_LINK;
        end else if (out_free) begin
          res_fire  = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r == CMD_CREATE) begin
            if (free_slot.found) begin
              slot_we                     = 1'b1;
              slot_wa                     = free_slot.slot;
              slot_wd.count               = COUNT_BITS'(init_r);
              in_use_nxt[free_slot.slot]  = 1'b1;
              qne_nxt[free_slot.slot]     = 1'b0;
              slot_out_nxt                = free_slot.slot;
              would_block_nxt             = (init_r == '0);
            end else begin
              status_nxt   = ST_FULL;
              slot_out_nxt = '0;
            end
          end else if (!slot_ok) begin
            status_nxt = ST_INVALID;
          end else begin
            case (cmd_r)
              CMD_WAIT: begin
                slot_we = 1'b1;
                if (slot_rd_r.count != '0) begin
                  slot_wd.count   = slot_rd_r.count - COUNT_BITS'(1);
                  would_block_nxt = (slot_rd_r.count == COUNT_BITS'(1));
                end else begin
                  // Queue the caller at the tail.
                  if (qne_r[idx_r]) begin
                    link_we = 1'b1;
                  end else begin
                    slot_wd.head = pid_r;
                    qne_nxt[idx_r] = 1'b1;
                  end
                  slot_wd.tail    = pid_r;
                  status_nxt      = ST_BLOCKED;
                  would_block_nxt = 1'b1;
                end
              end
              CMD_POST: begin
                if (qne_r[idx_r]) begin
                  // Last waiter leaves; the count stays.
                  wake_valid_nxt  = 1'b1;
                  wake_pid_nxt    = slot_rd_r.head;
                  qne_nxt[idx_r]  = 1'b0;
                  would_block_nxt = (slot_rd_r.count == '0);
                end else if (slot_rd_r.count != COUNT_MAX) begin
                  slot_we       = 1'b1;
                  slot_wd.count = slot_rd_r.count + COUNT_BITS'(1);
                end
              end
              CMD_CLOSE: begin
                in_use_nxt[idx_r] = 1'b0;
                qne_nxt[idx_r]    = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_LINK: begin
        // Advance the queue head to the next waiter.
        if (out_free) begin
          res_fire        = 1'b1;
          state_nxt       = S_IDLE;
          slot_we         = 1'b1;
          slot_wd.head    = link_rd_r;
          wake_valid_nxt  = 1'b1;
          wake_pid_nxt    = slot_rd_r.head;
          would_block_nxt = (slot_rd_r.count == '0);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      qne_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      qne_r    <= qne_nxt;
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (res_fire) begin
      status_r      <= status_nxt;
      slot_out_r    <= slot_out_nxt;
      wake_valid_r  <= wake_valid_nxt;
      wake_pid_r    <= wake_pid_nxt;
      would_block_r <= would_block_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_out    = slot_out_r;
  assign out_wake_valid  = wake_valid_r;
  assign out_wake_pid    = wake_pid_r;
  assign out_would_block = would_block_r;

endmodule

`default_nettype wire
